@@ design/rsr_pkg.sv @@
package rsr_pkg;

  localparam int CoordWidth  = 11;
  localparam int RadiusWidth = CoordWidth - 1;
  localparam int OutWidth    = CoordWidth + 1;
  localparam int ErrWidth    = CoordWidth + 3;
  localparam int ColorWidth  = 24;

  localparam int InFieldBits  = 2 * CoordWidth + 2 * RadiusWidth + ColorWidth;
  localparam int InDataWidth  = ((InFieldBits + 7) / 8) * 8;
  localparam int OutFieldBits = 3 * OutWidth + ColorWidth + 1;
  localparam int OutDataWidth = ((OutFieldBits + 7) / 8) * 8;
  localparam int OutUserWidth = 2;

  localparam int SpansPerRow = 8;
  localparam int SpanIdxWidth = $clog2(SpansPerRow);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic        [CoordWidth-1:0] row_t;
  typedef logic        [RadiusWidth-1:0] radius_t;
  typedef logic signed [OutWidth-1:0]   ocoord_t;
  typedef logic signed [ErrWidth-1:0]   err_t;
  typedef logic        [ColorWidth-1:0] color_t;

  // one row snapshot handed to the span sequencer
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t xo;
    coord_t xi;
    row_t   y;
    color_t color;
    logic   done;
  } row_snap_t;

endpackage

@@ design/ring_span_rasterizer_top.sv @@
// a step beat is held in the row snapshot register; its spans then load the
// output register. throughput: one span beat per cycle while the receiver does not
//   stall, with 8 span beats per step item from the registered row snapshot
// a start item is taken once the previous row has been handed out
// async reset (rst_ni low) clears control state: no ring active, no beat pending
module ring_span_rasterizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // center_x, center_y, inner_radius, outer_radius, color, zero pad
  input  logic [rsr_pkg::InDataWidth-1:0]    s_axis_tdata,
  // operation
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fixed_coord, span_begin, span_end, span_color, ring_done, zero pad
  output logic [rsr_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // vertical, empty_res
  output logic [rsr_pkg::OutUserWidth-1:0]   m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CW = rsr_pkg::CoordWidth;
  localparam int RW = rsr_pkg::RadiusWidth;
  localparam int OW = rsr_pkg::OutWidth;
  localparam int EW = rsr_pkg::ErrWidth;
  localparam int KW = rsr_pkg::SpanIdxWidth;

  // input field unpacking
  rsr_pkg::coord_t  in_cx;
  rsr_pkg::coord_t  in_cy;
  rsr_pkg::radius_t in_inner;
  rsr_pkg::radius_t in_outer;
  rsr_pkg::color_t  in_color;
  rsr_pkg::op_e     in_op;

  assign in_cx    = s_axis_tdata[CW-1:0];
  assign in_cy    = s_axis_tdata[2*CW-1:CW];
  assign in_inner = s_axis_tdata[2*CW+RW-1:2*CW];
  assign in_outer = s_axis_tdata[2*CW+2*RW-1:2*CW+RW];
  assign in_color = s_axis_tdata[2*CW+2*RW+rsr_pkg::ColorWidth-1:2*CW+2*RW];
  assign in_op    = rsr_pkg::op_e'(s_axis_tuser);

  // ring state
  logic             active_q;
  rsr_pkg::coord_t  cx_q, cy_q;
  rsr_pkg::radius_t inner_q;
  rsr_pkg::color_t  color_q;
  rsr_pkg::coord_t  xo_q, xi_q;
  rsr_pkg::row_t    row_q;
  rsr_pkg::err_t    eo_q, ei_q;

  // row snapshot and sequencer
  logic               snap_valid_q;
  rsr_pkg::row_snap_t snap_q;
  logic [KW-1:0]      idx_q;

  // output register
  logic               out_valid_q;
  logic               out_vert_q;
  rsr_pkg::ocoord_t   out_fixed_q, out_begin_q, out_end_q;
  rsr_pkg::color_t    out_color_q;
  logic               out_empty_q, out_last_q, out_done_q;

  logic out_load, seq_last, snap_free, in_acc, step_acc, start_acc;

  assign out_load  = snap_valid_q && (!out_valid_q || m_axis_tready);
  assign seq_last  = (idx_q == KW'(rsr_pkg::SpansPerRow - 1));
  assign snap_free = !snap_valid_q || (out_load && seq_last);
  assign s_axis_tready = snap_free;
  assign in_acc    = s_axis_tvalid && snap_free;
  assign start_acc = in_acc && (in_op == rsr_pkg::OP_START);
  assign step_acc  = in_acc && (in_op == rsr_pkg::OP_STEP) && active_q;

  // tracker advance
  logic [CW:0]     ny;
  rsr_pkg::err_t   ny_e, xo_e, xi_e, eo_d, ei_d;
  rsr_pkg::coord_t xo_d, xi_d;
  logic            done_d;

  always_comb begin
    ny   = {1'b0, row_q} + (CW+1)'(1);
    ny_e = EW'(ny);
    xo_e = EW'(xo_q);
    xi_e = EW'(xi_q);
    xo_e = {{(EW-CW){xo_q[CW-1]}}, xo_q};
    xi_e = {{(EW-CW){xi_q[CW-1]}}, xi_q};
    if (eo_q[EW-1]) begin
      xo_d = xo_q;
      eo_d = eo_q + EW'({ny, 1'b1});
    end else begin
      xo_d = xo_q - CW'(1);
      eo_d = eo_q + ((ny_e - xo_e + EW'(2)) <<< 1);
    end
    if (ny > (CW+1)'(inner_q)) begin
      xi_d = ny[CW-1:0];
      ei_d = ei_q;
    end else if (ei_q[EW-1]) begin
      xi_d = xi_q;
      ei_d = ei_q + EW'({ny, 1'b1});
    end else begin
      xi_d = xi_q - CW'(1);
      ei_d = ei_q + ((ny_e - xi_e + EW'(2)) <<< 1);
    end
    done_d = $signed({xo_d[CW-1], xo_d}) < $signed({1'b0, ny[CW-1:0]});
  end

  // span of the current sequencer index
  logic             sp_vert, neg_fixed, neg_span;
  rsr_pkg::ocoord_t s_cx, s_cy, s_xo, s_xi, s_y, base_f, base_s;
  rsr_pkg::ocoord_t sp_fixed, sp_begin, sp_end;
  logic             sp_empty;

  always_comb begin
    sp_vert = idx_q[0];
    case (idx_q)
      3'd3, 3'd4, 3'd5, 3'd6: neg_fixed = 1'b1;
      default:                neg_fixed = 1'b0;
    endcase
    case (idx_q)
      3'd2, 3'd4, 3'd5, 3'd7: neg_span = 1'b1;
      default:                neg_span = 1'b0;
    endcase
    s_cx = OW'(snap_q.cx);
    s_cy = OW'(snap_q.cy);
    s_xo = OW'(snap_q.xo);
    s_xi = OW'(snap_q.xi);
    s_y  = OW'(snap_q.y);
    // fixed coordinate is the center on the other axis
    base_f   = sp_vert ? s_cx : s_cy;
    base_s   = sp_vert ? s_cy : s_cx;
    sp_fixed = neg_fixed ? base_f - s_y : base_f + s_y;
    if (neg_span) begin
      sp_begin = base_s - s_xo;
      sp_end   = base_s - s_xi;
    end else begin
      sp_begin = base_s + s_xi;
      sp_end   = base_s + s_xo;
    end
    sp_empty = sp_begin > sp_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cx_q         <= '0;
      cy_q         <= '0;
      inner_q      <= '0;
      color_q      <= '0;
      xo_q         <= '0;
      xi_q         <= '0;
      row_q        <= '0;
      eo_q         <= '0;
      ei_q         <= '0;
      snap_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (start_acc) begin
        active_q <= 1'b1;
        cx_q     <= in_cx;
        cy_q     <= in_cy;
        inner_q  <= in_inner;
        color_q  <= in_color;
        xo_q     <= CW'(in_outer);
        xi_q     <= CW'(in_inner);
        row_q    <= '0;
        eo_q     <= EW'(1) - EW'(in_outer);
        ei_q     <= EW'(1) - EW'(in_inner);
      end else if (step_acc) begin
        xo_q  <= xo_d;
        xi_q  <= xi_d;
        row_q <= ny[CW-1:0];
        eo_q  <= eo_d;
        ei_q  <= ei_d;
        if (done_d) begin
          active_q <= 1'b0;
        end
      end

      if (step_acc) begin
        snap_valid_q <= 1'b1;
      end else if (snap_free) begin
        snap_valid_q <= 1'b0;
      end

      if (out_load) begin
        idx_q <= idx_q + KW'(1);
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      snap_q.cx    <= cx_q;
      snap_q.cy    <= cy_q;
      snap_q.xo    <= xo_q;
      snap_q.xi    <= xi_q;
      snap_q.y     <= row_q;
      snap_q.color <= color_q;
      snap_q.done  <= done_d;
    end
    if (out_load) begin
      out_vert_q  <= sp_vert;
      out_fixed_q <= sp_fixed;
      out_begin_q <= sp_begin;
      out_end_q   <= sp_end;
      out_color_q <= snap_q.color;
      out_empty_q <= sp_empty;
      out_last_q  <= seq_last;
      out_done_q  <= seq_last && snap_q.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_empty_q, out_vert_q};
  assign m_axis_tdata  = rsr_pkg::OutDataWidth'({out_done_q, out_color_q, out_end_q,
                                                 out_begin_q, out_fixed_q});

`ifndef SYNTHESIS
  a_idx_needs_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> snap_valid_q)
    else $error("span index running without a row snapshot");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && seq_last) |=> (out_valid_q && out_last_q))
    else $error("eighth span not marked last");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("ring done outside the last span of a row");

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_acc |=> (row_q == $past(row_q) + CW'(1)))
    else $error("row counter did not advance on a step");
`endif

endmodule

@@ tb/sv/ring_span_rasterizer_top_tb.sv @@
module ring_span_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 150;
  localparam int DrainCycles   = 20;
  localparam int HoldOffCycles = 300;

  typedef struct {
    rsr_pkg::coord_t  cx;
    rsr_pkg::coord_t  cy;
    rsr_pkg::radius_t inner;
    rsr_pkg::radius_t outer;
    rsr_pkg::color_t  color;
  } ring_geom_t;

  typedef struct {
    logic             vertical;
    rsr_pkg::ocoord_t fixed_coord;
    rsr_pkg::ocoord_t span_lo;
    rsr_pkg::ocoord_t span_hi;
    rsr_pkg::color_t  color;
    logic             empty;
    logic             tail;
    logic             done;
  } span_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rsr_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rsr_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic [rsr_pkg::OutUserWidth-1:0] m_axis_tuser;
  logic                             m_axis_tlast;

  ring_span_rasterizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ring tracker state mirrored from the block
  logic             ring_on = 1'b0;
  rsr_pkg::coord_t  ring_cx = '0;
  rsr_pkg::coord_t  ring_cy = '0;
  rsr_pkg::radius_t ring_inner = '0;
  rsr_pkg::color_t  ring_color = '0;
  rsr_pkg::coord_t  edge_out = '0;
  rsr_pkg::coord_t  edge_in = '0;
  rsr_pkg::row_t    row_y = '0;
  rsr_pkg::err_t    err_out = '0;
  rsr_pkg::err_t    err_in = '0;

  span_t expected_spans[$];
  int    error_count = 0;
  int    beats_sent = 0;
  int    useful_beats = 0;
  int    spans_checked = 0;
  int    rings_finished = 0;
  int    idle_cycles = 0;
  int    hold_cycles = 0;
  bit    no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic ring_geom_t rand_fields();
    ring_geom_t g;
    g.cx    = rsr_pkg::coord_t'($urandom);
    g.cy    = rsr_pkg::coord_t'($urandom);
    g.inner = rsr_pkg::radius_t'($urandom);
    g.outer = rsr_pkg::radius_t'($urandom);
    g.color = rsr_pkg::color_t'($urandom);
    return g;
  endfunction

  // mostly small rings so that they run to completion quickly
  function automatic ring_geom_t rand_geom(input bit big);
    ring_geom_t g;
    int outer, inner, r;
    g = rand_fields();
    if (big) outer = $urandom_range(0, 1023);
    else if ($urandom_range(0, 9) == 0) outer = $urandom_range(25, 60);
    else outer = $urandom_range(0, 24);
    r = $urandom_range(0, 9);
    if (r < 6) inner = $urandom_range(0, outer);
    else if (r < 9) inner = $urandom_range(0, (outer + 10 > 1023) ? 1023 : outer + 10);
    else inner = $urandom_range(0, 1023);
    g.outer = rsr_pkg::radius_t'(outer);
    g.inner = rsr_pkg::radius_t'(inner);
    return g;
  endfunction

  task automatic push_span(input logic vert, input int fixed, input int lo, input int hi,
                           input logic tail, input logic done);
    span_t s;
    s.vertical    = vert;
    s.fixed_coord = rsr_pkg::ocoord_t'(fixed);
    s.span_lo     = rsr_pkg::ocoord_t'(lo);
    s.span_hi     = rsr_pkg::ocoord_t'(hi);
    s.color       = ring_color;
    s.empty       = (lo > hi);
    s.tail        = tail;
    s.done        = done;
    expected_spans.push_back(s);
  endtask

  task automatic rasterize_beat(input rsr_pkg::op_e op, input ring_geom_t g);
    int   cx, cy, xo, xi, y, ny, no, ni, eo, ei;
    logic done;
    if (op == rsr_pkg::OP_START) begin
      ring_cx    = g.cx;
      ring_cy    = g.cy;
      ring_inner = g.inner;
      ring_color = g.color;
      edge_out   = rsr_pkg::coord_t'(int'(g.outer));
      edge_in    = rsr_pkg::coord_t'(int'(g.inner));
      row_y      = '0;
      err_out    = rsr_pkg::err_t'(1 - int'(g.outer));
      err_in     = rsr_pkg::err_t'(1 - int'(g.inner));
      ring_on    = 1'b1;
      useful_beats++;
      return;
    end
    // a step with no ring in progress is dropped
    if (!ring_on) return;
    useful_beats++;
    cx = int'(ring_cx);
    cy = int'(ring_cy);
    xo = int'(edge_out);
    xi = int'(edge_in);
    y  = int'(row_y);
    ny = y + 1;
    no = xo;
    ni = xi;
    eo = int'(err_out);
    ei = int'(err_in);
    if (eo < 0) begin
      eo += 2 * ny + 1;
    end else begin
      no = no - 1;
      eo += 2 * (ny - no + 1);
    end
    // past the inner radius the inner edge just tracks the row
    if (ny > int'(ring_inner)) begin
      ni = ny;
    end else if (ei < 0) begin
      ei += 2 * ny + 1;
    end else begin
      ni = ni - 1;
      ei += 2 * (ny - ni + 1);
    end
    row_y    = rsr_pkg::row_t'(ny);
    edge_out = rsr_pkg::coord_t'(no);
    edge_in  = rsr_pkg::coord_t'(ni);
    err_out  = rsr_pkg::err_t'(eo);
    err_in   = rsr_pkg::err_t'(ei);
    done     = int'(edge_out) < int'(row_y);
    if (done) ring_on = 1'b0;
    push_span(1'b0, cy + y, cx + xi, cx + xo, 1'b0, 1'b0);
    push_span(1'b1, cx + y, cy + xi, cy + xo, 1'b0, 1'b0);
    push_span(1'b0, cy + y, cx - xo, cx - xi, 1'b0, 1'b0);
    push_span(1'b1, cx - y, cy + xi, cy + xo, 1'b0, 1'b0);
    push_span(1'b0, cy - y, cx - xo, cx - xi, 1'b0, 1'b0);
    push_span(1'b1, cx - y, cy - xo, cy - xi, 1'b0, 1'b0);
    push_span(1'b0, cy - y, cx + xi, cx + xo, 1'b0, 1'b0);
    push_span(1'b1, cx + y, cy - xo, cy - xi, 1'b1, done);
  endtask

  // entered and left at a falling edge
  task automatic send_item(input rsr_pkg::op_e op, input ring_geom_t g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= rsr_pkg::InDataWidth'({g.color, g.outer, g.inner, g.cy, g.cx});
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_beat(op, g);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_ring(input ring_geom_t g, input int max_steps);
    int steps;
    steps = 0;
    send_item(rsr_pkg::OP_START, g);
    while (ring_on && steps < max_steps) begin
      send_item(rsr_pkg::OP_STEP, rand_fields());
      steps++;
    end
  endtask

  task automatic test_idle_steps();
    repeat (3) send_item(rsr_pkg::OP_STEP, rand_fields());
  endtask

  task automatic test_extreme_geometry();
    ring_geom_t g;
    // zero radius at the most negative column: a single row
    g = '{cx: rsr_pkg::coord_t'(-1024), cy: rsr_pkg::coord_t'(1023), inner: '0, outer: '0,
          color: '0};
    run_ring(g, 10);
    send_item(rsr_pkg::OP_STEP, rand_fields());
    // largest radii, abandoned by the next start
    g = '{cx: rsr_pkg::coord_t'(1023), cy: rsr_pkg::coord_t'(-1024), inner: '1, outer: '1,
          color: '1};
    run_ring(g, 3);
    // inner radius beyond the outer one gives empty spans
    g = '{cx: rsr_pkg::coord_t'(5), cy: rsr_pkg::coord_t'(-7), inner: rsr_pkg::radius_t'(9),
          outer: rsr_pkg::radius_t'(4), color: rsr_pkg::color_t'(24'h5a3c96)};
    run_ring(g, 100);
    // zero inner radius fills the disc
    g = '{cx: rsr_pkg::coord_t'(-300), cy: rsr_pkg::coord_t'(200), inner: '0,
          outer: rsr_pkg::radius_t'(6), color: rsr_pkg::color_t'(24'ha5c369)};
    run_ring(g, 100);
  endtask

  task automatic test_random_rings(input int target);
    int goal, r, max_steps;
    goal = useful_beats + target;
    while (useful_beats < goal) begin
      r = $urandom_range(0, 99);
      if (r < 6) max_steps = $urandom_range(1, 6);
      else if (r < 16) max_steps = $urandom_range(0, 5);
      else max_steps = 100000;
      run_ring(rand_geom(r < 6), max_steps);
      // stray steps, dropped unless the ring was cut short
      if ($urandom_range(0, 7) == 0) send_item(rsr_pkg::OP_STEP, rand_fields());
    end
  endtask

  task automatic test_receiver_holdoff();
    ring_geom_t g;
    g = rand_geom(1'b0);
    g.outer = rsr_pkg::radius_t'(30);
    g.inner = rsr_pkg::radius_t'(5);
    hold_cycles = HoldOffCycles;
    run_ring(g, 100000);
  endtask

  task automatic test_back_to_back();
    ring_geom_t g;
    no_idle = 1'b1;
    g = rand_geom(1'b0);
    g.outer = rsr_pkg::radius_t'(12);
    g.inner = rsr_pkg::radius_t'(4);
    run_ring(g, 100000);
    run_ring(rand_geom(1'b0), 100000);
    no_idle = 1'b0;
  endtask

  // receiver with random stalls and an occasional long hold-off
  initial begin
    int gap, n;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : span_check
    span_t got, e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.vertical    = m_axis_tuser[0];
      got.empty       = m_axis_tuser[1];
      got.tail        = m_axis_tlast;
      got.fixed_coord = m_axis_tdata[rsr_pkg::OutWidth-1:0];
      got.span_lo     = m_axis_tdata[2*rsr_pkg::OutWidth-1:rsr_pkg::OutWidth];
      got.span_hi     = m_axis_tdata[3*rsr_pkg::OutWidth-1:2*rsr_pkg::OutWidth];
      got.color       = m_axis_tdata[3*rsr_pkg::OutWidth+rsr_pkg::ColorWidth-1:
                                     3*rsr_pkg::OutWidth];
      got.done        = m_axis_tdata[3*rsr_pkg::OutWidth+rsr_pkg::ColorWidth];
      if (expected_spans.size() == 0) begin
        report_mismatch("span beat with no span expected");
      end else begin
        e = expected_spans.pop_front();
        if (got.vertical !== e.vertical)
          report_mismatch($sformatf("span %0d vertical got %0b exp %0b",
                                    spans_checked, got.vertical, e.vertical));
        if (got.fixed_coord !== e.fixed_coord)
          report_mismatch($sformatf("span %0d fixed_coord got %0d exp %0d",
                                    spans_checked, got.fixed_coord, e.fixed_coord));
        if (got.span_lo !== e.span_lo)
          report_mismatch($sformatf("span %0d span_begin got %0d exp %0d",
                                    spans_checked, got.span_lo, e.span_lo));
        if (got.span_hi !== e.span_hi)
          report_mismatch($sformatf("span %0d span_end got %0d exp %0d",
                                    spans_checked, got.span_hi, e.span_hi));
        if (got.color !== e.color)
          report_mismatch($sformatf("span %0d span_color got %06h exp %06h",
                                    spans_checked, got.color, e.color));
        if (got.empty !== e.empty)
          report_mismatch($sformatf("span %0d empty_res got %0b exp %0b",
                                    spans_checked, got.empty, e.empty));
        if (got.tail !== e.tail)
          report_mismatch($sformatf("span %0d last_of_step got %0b exp %0b",
                                    spans_checked, got.tail, e.tail));
        if (got.done !== e.done)
          report_mismatch($sformatf("span %0d ring_done got %0b exp %0b",
                                    spans_checked, got.done, e.done));
        if (e.done) rings_finished++;
        spans_checked++;
      end
    end
  end

  // counts cycles in which neither side moves a beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[ring_span_rasterizer_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_steps();
    test_extreme_geometry();
    test_receiver_holdoff();
    test_back_to_back();
    test_random_rings(RandomItems);
    s_axis_tvalid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d input beats (%0d acted on), %0d span beats checked,",
             beats_sent, useful_beats, spans_checked);
    $display("%0d rings finished, with idle steps, extreme and inverted radii,",
             rings_finished);
    $display("abandoned rings and a long output hold");
    if (error_count == 0) begin
      $display("[ring_span_rasterizer_top] OK");
    end else begin
      $display("[ring_span_rasterizer_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rsr_pkg.sv
design/ring_span_rasterizer_top.sv
tb/sv/ring_span_rasterizer_top_tb.sv
